// ----- rtl/core/cfp_pkg.sv -----
`default_nettype none

package cfp_pkg;

    localparam int POS_W      = 17;
    localparam int HEAD_DEPTH = 5;

    localparam logic [POS_W-1:0] POS_MAX      = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_KIND     = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd2;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 17'd4;
    localparam logic [POS_W-1:0] POS_LAST_MAX = 17'd65534;
    localparam logic [POS_W-1:0] POS_END_OFS  = 17'd5;

    localparam logic [7:0]  CRC_POLY      = 8'h31;
    localparam logic [7:0]  CRC_TOP_BIT   = 8'h80;
    localparam logic [15:0] LEN_THRESHOLD = 16'd5;
    localparam logic [15:0] LEN_TEST      = 16'd1;

    typedef enum logic [2:0] {
        CFG_START_MARKER   = 3'd0,
        CFG_END_MARKER     = 3'd1,
        CFG_THRESHOLD_CODE = 3'd2,
        CFG_LED_CODE       = 3'd3,
        CFG_BUZZER_CODE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] threshold_type_code;
        logic [7:0] led_type_code;
        logic [7:0] buzzer_type_code;
    } cfg_t;

    typedef struct packed {
        logic                       start_ok;
        logic                       crc_ok;
        logic                       length_ok;
        logic [7:0]                 kind;
        logic [15:0]                len;
        logic [HEAD_DEPTH-1:0][7:0] head;
    } frame_status_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ reverse8(b);
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP_BIT) != 8'h00)
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfp_if.sv -----
`default_nettype none

interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cfp_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [7:0]  command_type;
    logic [7:0]  parameter_id;
    logic [31:0] command_value;

    modport source (output valid, output frame_ok, output command_type,
                    output parameter_id, output command_value, input ready);
    modport sink   (input valid, input frame_ok, input command_type,
                    input parameter_id, input command_value, output ready);
endinterface

interface cfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [7:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/command_frame_parser.sv -----
`default_nettype none

// Command frame parser. Takes one frame byte per cycle on byte_chan (frame_end
// high on the last byte) and returns one registered result per frame on
// result_chan. A frame is start marker, type, 16-bit little-endian payload
// length, payload, CRC-8/MAXIM byte over start marker through payload, end
// marker. Failing frames, unknown types and wrong payload sizes give frame_ok
// low with all fields zero. The rate is one byte per cycle, set by the
// unrolled CRC update and the position compares in the frame tracker; a held
// result stalls only on a final byte. The user must write the marker and type
// registers on cfg_chan only with no frame in flight; the block doesn't enforce it.
module command_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    cfp_byte_if.sink     byte_chan,
    cfp_result_if.source result_chan,
    cfp_cfg_if.sink      cfg_chan
);
    import cfp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic          advance;
    logic          load;
    logic          stall;
    logic          take;
    cfg_t          cfg;
    frame_status_t status;

    assign advance         = in_valid_reg && (!in_last_reg || !stall);
    assign load            = advance && in_last_reg;
    assign byte_chan.ready = !in_valid_reg || advance;
    assign take            = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= byte_chan.data_byte;
            in_last_reg <= byte_chan.frame_end;
        end
    end

    cfp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_chan (cfg_chan),
        .cfg      (cfg)
    );

    cfp_frame_tracker u_frame_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .frame_end (in_last_reg),
        .cfg       (cfg),
        .status    (status)
    );

    cfp_cmd_decode u_cmd_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .data_byte   (in_byte_reg),
        .cfg         (cfg),
        .status      (status),
        .result_chan (result_chan),
        .stall       (stall)
    );

endmodule

`default_nettype wire

// ----- rtl/core/cfp_cfg_regs.sv -----
`default_nettype none

module cfp_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    cfp_cfg_if.sink       cfg_chan,
    output cfp_pkg::cfg_t cfg
);
    import cfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_chan.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_chan.valid)
        begin
            case (cfg_index_t'(cfg_chan.reg_index))
                CFG_START_MARKER:   cfg_next.start_marker        = cfg_chan.wdata;
                CFG_END_MARKER:     cfg_next.end_marker          = cfg_chan.wdata;
                CFG_THRESHOLD_CODE: cfg_next.threshold_type_code = cfg_chan.wdata;
                CFG_LED_CODE:       cfg_next.led_type_code       = cfg_chan.wdata;
                CFG_BUZZER_CODE:    cfg_next.buzzer_type_code    = cfg_chan.wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker        <= 8'hAA;
            cfg_reg.end_marker          <= 8'h55;
            cfg_reg.threshold_type_code <= 8'h10;
            cfg_reg.led_type_code       <= 8'h11;
            cfg_reg.buzzer_type_code    <= 8'h12;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cfp_frame_tracker.sv -----
`default_nettype none

module cfp_frame_tracker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    input  cfp_pkg::cfg_t          cfg,
    output cfp_pkg::frame_status_t status
);
    import cfp_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic             start_ok_reg;
    logic             start_ok_next;
    logic [7:0]       kind_reg;
    logic [7:0]       kind_next;
    logic [15:0]      len_reg;
    logic [15:0]      len_next;
    logic             crc_ok_reg;
    logic             crc_ok_next;
    logic [HEAD_DEPTH-1:0][7:0] head_reg;
    logic [HEAD_DEPTH-1:0][7:0] head_next;

    logic [POS_W-1:0] crc_pos;
    logic [7:0]       crc_fed;

    assign crc_pos = {1'b0, len_reg} + POS_PAYLOAD;
    assign crc_fed = crc8_feed(crc_reg, data_byte);

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        start_ok_next = start_ok_reg;
        kind_next     = kind_reg;
        len_next      = len_reg;
        crc_ok_next   = crc_ok_reg;
        head_next     = head_reg;
        if (advance)
        begin
            if (pos_reg == '0)
            begin
                start_ok_next = (data_byte == cfg.start_marker);
                crc_next      = crc_fed;
            end
            else if (pos_reg == POS_KIND)
            begin
                kind_next = data_byte;
                crc_next  = crc_fed;
            end
            else if (pos_reg == POS_LEN_LO)
            begin
                len_next[7:0] = data_byte;
                crc_next      = crc_fed;
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                len_next[15:8] = data_byte;
                crc_next       = crc_fed;
            end
            else if (pos_reg < crc_pos)
            begin
                for (int i = 0; i < HEAD_DEPTH; i++)
                begin
                    if (pos_reg == POS_PAYLOAD + POS_W'(i))
                    begin
                        head_next[i] = data_byte;
                    end
                end
                crc_next = crc_fed;
            end
            else if (pos_reg == crc_pos)
            begin
                crc_ok_next = (reverse8(crc_reg) == data_byte);
            end

            if (frame_end)
            begin
                pos_next      = '0;
                crc_next      = '0;
                start_ok_next = 1'b0;
                kind_next     = '0;
                len_next      = '0;
                crc_ok_next   = 1'b0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            start_ok_reg <= 1'b0;
            kind_reg     <= '0;
            len_reg      <= '0;
            crc_ok_reg   <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            start_ok_reg <= start_ok_next;
            kind_reg     <= kind_next;
            len_reg      <= len_next;
            crc_ok_reg   <= crc_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    // status describes the frame before the byte now at the head; on a final
    // byte that can pass, this byte changes none of these fields
    assign status.start_ok  = start_ok_reg;
    assign status.crc_ok    = crc_ok_reg;
    assign status.length_ok = (pos_reg == {1'b0, len_reg} + POS_END_OFS) &&
                              (pos_reg <= POS_LAST_MAX);
    assign status.kind      = kind_reg;
    assign status.len       = len_reg;
    assign status.head      = head_reg;

`ifndef ASSERT_OFF
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> pos_reg == '0 && crc_reg == '0 && !start_ok_reg
                                 && !crc_ok_reg)
        else $error("frame state not cleared after final byte");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !frame_end && pos_reg == POS_MAX |=> pos_reg == POS_MAX)
        else $error("byte position wrapped");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !frame_end && pos_reg != POS_MAX |=>
            pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("byte position did not advance by one");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cfp_cmd_decode.sv -----
`default_nettype none

module cfp_cmd_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [7:0]             data_byte,
    input  cfp_pkg::cfg_t          cfg,
    input  cfp_pkg::frame_status_t status,
    cfp_result_if.source           result_chan,
    output logic                   stall
);
    import cfp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        ok_reg;
    logic        ok_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [7:0]  pid_reg;
    logic [7:0]  pid_next;
    logic [31:0] val_reg;
    logic [31:0] val_next;

    logic frame_good;
    logic is_threshold;
    logic is_test;

    assign frame_good   = status.start_ok && status.crc_ok && status.length_ok &&
                          (data_byte == cfg.end_marker);
    assign is_threshold = (status.kind == cfg.threshold_type_code);
    assign is_test      = (status.kind == cfg.led_type_code) ||
                          (status.kind == cfg.buzzer_type_code);

    assign stall = valid_reg && !result_chan.ready;

    always_comb
    begin
        ok_next   = 1'b0;
        type_next = '0;
        pid_next  = '0;
        val_next  = '0;
        if (frame_good && is_threshold && status.len == LEN_THRESHOLD)
        begin
            ok_next   = 1'b1;
            type_next = status.kind;
            pid_next  = status.head[0];
            val_next  = {status.head[4], status.head[3], status.head[2], status.head[1]};
        end
        else if (frame_good && !is_threshold && is_test && status.len == LEN_TEST)
        begin
            ok_next   = 1'b1;
            type_next = status.kind;
            val_next  = {24'h000000, status.head[0]};
        end
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg   <= ok_next;
            type_reg <= type_next;
            pid_reg  <= pid_next;
            val_reg  <= val_next;
        end
    end

    assign result_chan.valid         = valid_reg;
    assign result_chan.frame_ok      = ok_reg;
    assign result_chan.command_type  = type_reg;
    assign result_chan.parameter_id  = pid_reg;
    assign result_chan.command_value = val_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !stall)
        else $error("result loaded over an untaken result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ok_reg |-> type_reg == '0 && pid_reg == '0 && val_reg == '0)
        else $error("failed frame carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/cfp_tb_pkg.sv -----
`timescale 1ns / 100ps

package cfp_tb_pkg;

    import cfp_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [7:0]  ctype;
        logic [7:0]  pid;
        logic [31:0] value;
    } command_result_t;

    // CRC-8/MAXIM, reflected form (poly 0x31 reversed is 0x8C), LSB first
    function automatic logic [7:0] crc8_maxim_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ 8'h8C;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    class frame_checker;
        logic [7:0]      start_marker;
        logic [7:0]      end_marker;
        logic [7:0]      threshold_code;
        logic [7:0]      led_code;
        logic [7:0]      buzzer_code;

        logic [16:0]     position;
        logic [7:0]      crc;
        logic            sof_ok;
        logic [7:0]      kind;
        logic [15:0]     length;
        logic            crc_ok;
        logic [7:0]      head [5];

        command_result_t pending_cmds [$];
        int              mismatches;

        function new();
            start_marker   = 8'hAA;
            end_marker     = 8'h55;
            threshold_code = 8'h10;
            led_code       = 8'h11;
            buzzer_code    = 8'h12;
            foreach (head[i])
            begin
                head[i] = 8'h00;
            end
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position = '0;
            crc      = 8'h00;
            sof_ok   = 1'b0;
            kind     = 8'h00;
            length   = 16'h0000;
            crc_ok   = 1'b0;
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction

        function void set_reg(input cfg_index_t idx, input logic [7:0] v);
            case (idx)
                CFG_START_MARKER:   start_marker   = v;
                CFG_END_MARKER:     end_marker     = v;
                CFG_THRESHOLD_CODE: threshold_code = v;
                CFG_LED_CODE:       led_code       = v;
                CFG_BUZZER_CODE:    buzzer_code    = v;
                default: ;
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            int unsigned     p;
            int unsigned     total;
            command_result_t r;
            p = 32'(position);
            if (p == 0)
            begin
                sof_ok = (b == start_marker);
                crc    = crc8_maxim_next(crc, b);
            end
            else if (p == 1)
            begin
                kind = b;
                crc  = crc8_maxim_next(crc, b);
            end
            else if (p == 2)
            begin
                length[7:0] = b;
                crc         = crc8_maxim_next(crc, b);
            end
            else if (p == 3)
            begin
                length[15:8] = b;
                crc          = crc8_maxim_next(crc, b);
            end
            else if (p < 4 + length)
            begin
                if (p - 4 < 5)
                begin
                    head[p-4] = b;
                end
                crc = crc8_maxim_next(crc, b);
            end
            else if (p == 4 + length)
            begin
                crc_ok = (crc == b);
            end

            if (!last)
            begin
                if (position != 17'h1FFFF)
                begin
                    position++;
                end
                return;
            end

            total = p + 1;
            r = '0;
            r.ok = (total >= 6) && (total <= 65535) && sof_ok && (b == end_marker) &&
                   (total == 6 + length) && crc_ok;
            if (r.ok)
            begin
                if (kind == threshold_code)
                begin
                    if (length == 16'd5)
                    begin
                        r.pid   = head[0];
                        r.value = {head[4], head[3], head[2], head[1]};
                    end
                    else
                    begin
                        r.ok = 1'b0;
                    end
                end
                else if (kind == led_code || kind == buzzer_code)
                begin
                    if (length == 16'd1)
                    begin
                        r.value = {24'h000000, head[0]};
                    end
                    else
                    begin
                        r.ok = 1'b0;
                    end
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            if (r.ok)
            begin
                r.ctype = kind;
            end
            else
            begin
                r.pid   = 8'h00;
                r.value = 32'h0;
            end
            pending_cmds.push_back(r);
            clear_frame();
        endfunction

        function void check_result(input command_result_t got);
            command_result_t want;
            bit              bad;
            if (pending_cmds.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: unexpected result ok=%0d type=%02h pid=%02h value=%08h",
                             $time, got.ok, got.ctype, got.pid, got.value);
                end
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            bad = 1'b0;
            if (got.ok !== want.ok)
            begin
                bad = 1'b1;
            end
            if (got.ctype !== want.ctype)
            begin
                bad = 1'b1;
            end
            if (got.pid !== want.pid)
            begin
                bad = 1'b1;
            end
            if (got.value !== want.value)
            begin
                bad = 1'b1;
            end
            if (bad)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: mismatch exp ok=%0d type=%02h pid=%02h value=%08h", $time,
                             want.ok, want.ctype, want.pid, want.value);
                    $display("%0t:          got ok=%0d type=%02h pid=%02h value=%08h", $time,
                             got.ok, got.ctype, got.pid, got.value);
                end
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_command_frame_parser.sv -----
`timescale 1ns / 100ps

module tb_command_frame_parser;

    import cfp_pkg::*;
    import cfp_tb_pkg::*;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cfp_byte_if   byte_chan ();
    cfp_result_if result_chan ();
    cfp_cfg_if    cfg_chan ();

    command_frame_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan),
        .cfg_chan    (cfg_chan)
    );

    frame_checker cmd_track;

    logic [7:0] frame_bytes [$];
    logic [7:0] payload_bytes [$];
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         rx_hold_len;
    int         bytes_sent;

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        command_result_t seen;
        if (rst_n)
        begin
            if (byte_chan.valid && byte_chan.ready)
            begin
                cmd_track.take_byte(byte_chan.data_byte, byte_chan.frame_end);
            end
            if (result_chan.valid && result_chan.ready)
            begin
                seen.ok    = result_chan.frame_ok;
                seen.ctype = result_chan.command_type;
                seen.pid   = result_chan.parameter_id;
                seen.value = result_chan.command_value;
                cmd_track.check_result(seen);
            end
        end
    end

    // result receiver: random stalls per transfer, long hold on request
    initial
    begin
        int stall;
        result_chan.ready <= 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        result_chan.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (rx_idle_on && result_chan.valid && result_chan.ready)
            begin
                stall = $urandom_range(0, 18);
            end
            if (stall > 0)
            begin
                result_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                result_chan.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid     <= 1'b1;
        byte_chan.data_byte <= b;
        byte_chan.frame_end <= last;
        do
        begin
            @(posedge clk);
        end
        while (!byte_chan.ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        byte_chan.valid <= 1'b0;
        @(posedge clk);
        while (cmd_track.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] sof, input logic [7:0] eof,
                              input logic [7:0] thr, input logic [7:0] led,
                              input logic [7:0] buz);
        logic [7:0] vals [5];
        vals = '{sof, eof, thr, led, buz};
        for (int i = 0; i < 5; i++)
        begin
            cfg_chan.valid     <= 1'b1;
            cfg_chan.reg_index <= cfg_index_t'(i);
            cfg_chan.wdata     <= vals[i];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_chan.ready);
            cmd_track.set_reg(cfg_index_t'(i), vals[i]);
        end
        cfg_chan.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void make_frame(input logic [7:0] ftype, input int unsigned decl_len,
                                       input int unsigned pay_len, input bit bad_sof,
                                       input bit bad_crc, input bit bad_eof);
        logic [7:0] c;
        frame_bytes.delete();
        while (payload_bytes.size() < pay_len)
        begin
            payload_bytes.push_back(8'($urandom_range(0, 255)));
        end
        c = cmd_track.start_marker;
        if (bad_sof)
        begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        frame_bytes.push_back(c);
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(decl_len[7:0]);
        frame_bytes.push_back(decl_len[15:8]);
        for (int i = 0; i < pay_len; i++)
        begin
            frame_bytes.push_back(payload_bytes[i]);
        end
        c = 8'h00;
        foreach (frame_bytes[i])
        begin
            c = crc8_maxim_next(c, frame_bytes[i]);
        end
        if (bad_crc)
        begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        frame_bytes.push_back(c);
        c = cmd_track.end_marker;
        if (bad_eof)
        begin
            c = c ^ 8'($urandom_range(1, 255));
        end
        frame_bytes.push_back(c);
        payload_bytes.delete();
    endfunction

    function automatic void pick_known(output logic [7:0] code, output int unsigned plen);
        case ($urandom_range(0, 2))
            0:
            begin
                code = cmd_track.threshold_code;
                plen = 5;
            end
            1:
            begin
                code = cmd_track.led_code;
                plen = 1;
            end
            default:
            begin
                code = cmd_track.buzzer_code;
                plen = 1;
            end
        endcase
    endfunction

    task automatic random_frame();
        int          r;
        int          n;
        logic [7:0]  code;
        int unsigned plen;
        int unsigned decl;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
        begin
            tx_idle_on = !tx_idle_on;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            rx_idle_on = !rx_idle_on;
        end
        pick_known(code, plen);
        if (r < 55)
        begin
            make_frame(code, plen, plen, 0, 0, 0);
        end
        else if (r < 62)
        begin
            n = $urandom_range(0, 8);
            make_frame(code, n, n, 0, 0, 0);
        end
        else if (r < 68)
        begin
            make_frame(8'($urandom_range(0, 255)), plen, plen, 0, 0, 0);
        end
        else if (r < 74)
        begin
            make_frame(code, plen, plen, 0, 1, 0);
        end
        else if (r < 78)
        begin
            make_frame(code, plen, plen, 1, 0, 0);
        end
        else if (r < 82)
        begin
            make_frame(code, plen, plen, 0, 0, 1);
        end
        else if (r < 87)
        begin
            decl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
            make_frame(code, decl, $urandom_range(0, 8), 0, 0, 0);
        end
        else if (r < 92)
        begin
            make_frame(code, plen, plen, 0, 0, 0);
            n = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > n)
            begin
                void'(frame_bytes.pop_back());
            end
        end
        else
        begin
            // noise: random bytes, random frame boundaries
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 5) == 0));
            end
            return;
        end
        send_frame();
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            random_frame();
        end
    endtask

    task automatic run_directed();
        logic [7:0] thr;
        logic [7:0] led;
        logic [7:0] buz;
        thr = cmd_track.threshold_code;
        led = cmd_track.led_code;
        buz = cmd_track.buzzer_code;

        payload_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        make_frame(thr, 5, 5, 0, 0, 0);
        send_frame();
        payload_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        make_frame(thr, 5, 5, 0, 0, 0);
        send_frame();
        payload_bytes = '{8'h5A, 8'h01, 8'h00, 8'h00, 8'h80};
        make_frame(thr, 5, 5, 0, 0, 0);
        send_frame();
        payload_bytes = '{8'hFF};
        make_frame(led, 1, 1, 0, 0, 0);
        send_frame();
        payload_bytes = '{8'h00};
        make_frame(buz, 1, 1, 0, 0, 0);
        send_frame();
        make_frame(8'h00, 1, 1, 0, 0, 0);
        send_frame();
        make_frame(thr, 1, 1, 0, 0, 0);
        send_frame();
        make_frame(led, 5, 5, 0, 0, 0);
        send_frame();
        make_frame(led, 0, 0, 0, 0, 0);
        send_frame();
        make_frame(thr, 5, 5, 0, 1, 0);
        send_frame();
        make_frame(led, 1, 1, 1, 0, 0);
        send_frame();
        make_frame(buz, 1, 1, 0, 0, 1);
        send_frame();
        make_frame(thr, 5, 4, 0, 0, 0);
        send_frame();
        make_frame(led, 1, 2, 0, 0, 0);
        send_frame();
        send_byte(cmd_track.start_marker, 1'b1);
        make_frame(led, 1, 1, 0, 0, 0);
        void'(frame_bytes.pop_back());
        void'(frame_bytes.pop_back());
        send_frame();
    endtask

    initial
    begin
        logic [7:0] code;
        cmd_track   = new();
        tx_idle_on  = 1;
        rx_idle_on  = 1;
        rx_hold_len = 0;
        bytes_sent  = 0;

        byte_chan.valid     <= 1'b0;
        byte_chan.data_byte <= 8'h00;
        byte_chan.frame_end <= 1'b0;
        cfg_chan.valid      <= 1'b0;
        cfg_chan.reg_index  <= CFG_START_MARKER;
        cfg_chan.wdata      <= 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(100);
        wait_drained();

        write_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_random(80);
        wait_drained();

        write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(80);
        wait_drained();

        code = 8'($urandom_range(0, 255));
        write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), code, code,
                   8'($urandom_range(0, 255)));
        run_random(80);
        wait_drained();

        write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        run_random(50);
        // hold the receiver, keep the sender busy so the block backs up
        rx_hold_len = 400;
        tx_idle_on  = 0;
        repeat (20) random_frame();
        // pause the sender until every result is in
        wait_drained();
        tx_idle_on = 1;
        run_random(50);
        wait_drained();

        write_regs(8'hAA, 8'h55, 8'h40, 8'h41, 8'h41);
        run_random(70);
        wait_drained();

        if (cmd_track.mismatches == 0 && cmd_track.pending() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
